>>> hw/rtl/xbr_pkg.sv
// Shared types and codes for the xorshift bounded random block.
package xbr_pkg;

  localparam int unsigned StateW = 128;
  localparam int unsigned WordW  = 64;
  localparam int unsigned ReqW   = 2;
  localparam int unsigned CfgIdxW = 1;

  // Xorshift shift amounts
  localparam int unsigned Sh32A = 11;
  localparam int unsigned Sh32B = 8;
  localparam int unsigned Sh32C = 19;
  localparam int unsigned Sh64A = 23;
  localparam int unsigned Sh64B = 18;
  localparam int unsigned Sh64C = 5;

  // Reset state: seed_low = 1, seed_high = 0
  localparam logic [WordW-1:0] SeedLowRst  = 64'd1;
  localparam logic [WordW-1:0] SeedHighRst = 64'd0;

  typedef enum logic [ReqW-1:0] {
    REQ_RAW   = 2'd0,
    REQ_UPTO  = 2'd1,
    REQ_BELOW = 2'd2,
    REQ_RSVD  = 2'd3
  } req_t;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_SEED_LOW  = 1'b0,
    CFG_SEED_HIGH = 1'b1
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PREP,
    ST_DRAW,
    ST_CHECK
  } seq_state_t;

endpackage

>>> hw/rtl/xbr_step.sv
// One generator step: xorshift128 (32-bit) or xorshift128+ (64-bit).
module xbr_step (
  input  logic [xbr_pkg::StateW-1:0] state_i,
  input  logic                       wide_i,
  output logic [xbr_pkg::StateW-1:0] state_o,
  output logic [xbr_pkg::WordW-1:0]  draw_o
);
  import xbr_pkg::*;

  logic [31:0] w0, w1, w2, w3, t32, new3;
  logic [WordW-1:0] ha, hb, a2, new_hi, sum;

  always_comb begin
    w0 = state_i[31:0];
    w1 = state_i[63:32];
    w2 = state_i[95:64];
    w3 = state_i[127:96];
    t32  = w0 ^ (w0 << Sh32A);
    new3 = (t32 ^ (t32 >> Sh32B)) ^ (w3 ^ (w3 >> Sh32C));

    ha = state_i[63:0];
    hb = state_i[127:64];
    sum = ha + hb;
    a2 = ha ^ (ha << Sh64A);
    new_hi = a2 ^ hb ^ (a2 >> Sh64B) ^ (hb >> Sh64C);

    if (wide_i) begin
      state_o = {new_hi, hb};
      draw_o  = sum;
    end else begin
      state_o = {new3, w3, w2, w1};
      draw_o  = {32'd0, new3};
    end
  end

endmodule

>>> hw/rtl/xbr_cover.sv
// Smallest all-ones cover of a limit (smear the top set bit down).
module xbr_cover (
  input  logic [xbr_pkg::WordW-1:0] lim_i,
  output logic [xbr_pkg::WordW-1:0] mask_o
);
  import xbr_pkg::*;

  logic [WordW-1:0] v1, v2, v4, v8, v16;

  always_comb begin
    v1  = lim_i | (lim_i >> 1);
    v2  = v1 | (v1 >> 2);
    v4  = v2 | (v2 >> 4);
    v8  = v4 | (v4 >> 8);
    v16 = v8 | (v8 >> 16);
    mask_o = v16 | (v16 >> 32);
  end

endmodule

>>> hw/rtl/xorshift_bounded_random_top.sv
// Top level: xorshift bounded random source with its draw sequencer.
//
//  channel | dir | ports                                     | word
//  in      | in  | in_valid, in_stall, in_req_type/wide/bound | one request
//  out     | out | out_valid, out_stall, out_value           | one drawn value
//  cfg     | in  | cfg_we, cfg_index, cfg_data               | one seed half
//
// Sequence: a raw draw goes IDLE, DRAW, CHECK, then the output register;
//   a bounded draw goes IDLE, PREP, DRAW, CHECK, and back to DRAW for
//   every rejected draw (step, then compare). A zero result (zero
//   inclusive bound, exclusive bound <= 1) goes from IDLE to CHECK. The
//   step unit and the reject compare are used once per draw, in order.
// Reset: sync, active low; state loads seed_low=1 and seed_high=0.
// Stalls: in_stall is high while a request is in work; a finished word
//   waits in CHECK until the output register is free, so out_stall only
//   holds the sequencer, no draw is lost.
module xorshift_bounded_random_top (
  input  logic                         clk,
  input  logic                         rst_n,
  // request channel
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [xbr_pkg::ReqW-1:0]     in_req_type,
  input  logic                         in_wide,
  input  logic [xbr_pkg::WordW-1:0]    in_bound,
  // result channel
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [xbr_pkg::WordW-1:0]    out_value,
  // config write port
  input  logic                         cfg_we,
  input  logic [xbr_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [xbr_pkg::WordW-1:0]    cfg_data
);
  import xbr_pkg::*;

  seq_state_t        st_r, st_nxt;
  logic [StateW-1:0] gen_r, gen_nxt;     // generator words 3..0
  logic              wide_r, wide_nxt;
  logic [WordW-1:0]  lim_r, lim_nxt;     // accept draws <= lim
  logic [WordW-1:0]  mask_r, mask_nxt;
  logic [WordW-1:0]  draw_r, draw_nxt;   // masked draw awaiting compare
  logic              ovld_r, ovld_nxt;
  logic [WordW-1:0]  oval_r, oval_nxt;

  logic [StateW-1:0] step_state;
  logic [WordW-1:0]  step_draw;
  logic [WordW-1:0]  cover_msk;
  logic [WordW-1:0]  in_lim;
  logic              accept, out_free;

  xbr_step u_step (
    .state_i (gen_r),
    .wide_i  (wide_r),
    .state_o (step_state),
    .draw_o  (step_draw)
  );

  xbr_cover u_cover (
    .lim_i  (lim_r),
    .mask_o (cover_msk)
  );

  assign in_stall  = (st_r != ST_IDLE);
  assign accept    = in_valid && (st_r == ST_IDLE);
  assign out_free  = !ovld_r || !out_stall;
  assign out_valid = ovld_r;
  assign out_value = oval_r;
  // narrow mode uses only the low half of the bound
  assign in_lim = in_wide ? in_bound : {32'd0, in_bound[31:0]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= ST_IDLE;
      gen_r  <= {SeedHighRst, SeedLowRst};
      ovld_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      gen_r  <= gen_nxt;
      ovld_r <= ovld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    wide_r <= wide_nxt;
    lim_r  <= lim_nxt;
    mask_r <= mask_nxt;
    draw_r <= draw_nxt;
    oval_r <= oval_nxt;
  end

  always_comb begin
    st_nxt   = st_r;
    gen_nxt  = gen_r;
    wide_nxt = wide_r;
    lim_nxt  = lim_r;
    mask_nxt = mask_r;
    draw_nxt = draw_r;
    ovld_nxt = ovld_r && out_stall;
    oval_nxt = oval_r;

    if (cfg_we) begin
      unique case (cfg_index)
        CFG_SEED_LOW:  gen_nxt[63:0]   = cfg_data;
        CFG_SEED_HIGH: gen_nxt[127:64] = cfg_data;
        default:       gen_nxt = gen_r;
      endcase
    end

    unique case (st_r)
      ST_IDLE: begin
        if (accept) begin
          wide_nxt = in_wide;
          unique case (in_req_type)
            REQ_UPTO: begin
              if (in_lim == '0) begin
                lim_nxt  = '0;
                draw_nxt = '0;
                st_nxt   = ST_CHECK;
              end else begin
                lim_nxt = in_lim;
                st_nxt  = ST_PREP;
              end
            end
            REQ_BELOW: begin
              if (in_lim <= WordW'(1)) begin
                lim_nxt  = '0;
                draw_nxt = '0;
                st_nxt   = ST_CHECK;
              end else begin
                lim_nxt = in_lim - WordW'(1);
                st_nxt  = ST_PREP;
              end
            end
            default: begin
              // raw draw (unused code too): never rejected
              lim_nxt  = '1;
              mask_nxt = '1;
              st_nxt   = ST_DRAW;
            end
          endcase
        end
      end
      ST_PREP: begin
        mask_nxt = cover_msk;
        st_nxt   = ST_DRAW;
      end
      ST_DRAW: begin
        gen_nxt  = step_state;
        draw_nxt = step_draw & mask_r;
        st_nxt   = ST_CHECK;
      end
      ST_CHECK: begin
        if (draw_r > lim_r) begin
          st_nxt = ST_DRAW;
        end else if (out_free) begin
          ovld_nxt = 1'b1;
          oval_nxt = draw_r;
          st_nxt   = ST_IDLE;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

endmodule

>>> tb/tb_xorshift_bounded_random_top.sv
// Self-checking testbench for the xorshift bounded random top level.
module tb_xorshift_bounded_random_top;
  import xbr_pkg::*;

  localparam int unsigned CycleLimit  = 500000;
  localparam int unsigned SettleCycles = 12;   // slack for a late word after the queue empties
  localparam int unsigned RandPerPhase = 270;

  // ---------------------------------------------------------------------------
  // Scoreboard: owns a private copy of the 128-bit generator state and the
  // queue of values the block must still return, in acceptance order.
  // ---------------------------------------------------------------------------
  class xbr_draw_scoreboard;
    logic [31:0] gen_word[4];
    logic [63:0] draws_due[$];
    int unsigned failures;

    function new();
      failures = 0;
      load_seed(CFG_SEED_LOW, SeedLowRst);
      load_seed(CFG_SEED_HIGH, SeedHighRst);
    endfunction

    // a seed write lands on one 64-bit half at once
    function void load_seed(cfg_idx_t idx, logic [63:0] data);
      if (idx == CFG_SEED_LOW) begin
        gen_word[0] = data[31:0];
        gen_word[1] = data[63:32];
      end else begin
        gen_word[2] = data[31:0];
        gen_word[3] = data[63:32];
      end
    endfunction

    // xorshift128 over the four words
    function logic [31:0] next_narrow();
      logic [31:0] t;
      logic [31:0] last;
      t = gen_word[0] ^ (gen_word[0] << Sh32A);
      last = gen_word[3];
      gen_word[0] = gen_word[1];
      gen_word[1] = gen_word[2];
      gen_word[2] = last;
      gen_word[3] = (t ^ (t >> Sh32B)) ^ (last ^ (last >> Sh32C));
      return gen_word[3];
    endfunction

    // xorshift128+ over the two halves; output is the sum of the old halves
    function logic [63:0] next_wide();
      logic [63:0] a;
      logic [63:0] b;
      logic [63:0] sum;
      logic [63:0] nb;
      a = {gen_word[1], gen_word[0]};
      b = {gen_word[3], gen_word[2]};
      sum = a + b;
      gen_word[0] = b[31:0];
      gen_word[1] = b[63:32];
      a = a ^ (a << Sh64A);
      nb = a ^ b ^ (a >> Sh64B) ^ (b >> Sh64C);
      gen_word[2] = nb[31:0];
      gen_word[3] = nb[63:32];
      return sum;
    endfunction

    function logic [63:0] next_draw(logic wide);
      if (wide)
        return next_wide();
      return {32'd0, next_narrow()};
    endfunction

    // masked draws against the smallest all-ones cover, redrawn until in range
    function logic [63:0] draw_in_range(logic wide, logic [63:0] limit);
      logic [63:0] cmask;
      logic [63:0] r;
      if (limit == 64'd0)
        return 64'd0;
      cmask = limit;
      for (int s = 1; s < 64; s = s * 2)
        cmask = cmask | (cmask >> s);
      do begin
        r = cmask & next_draw(wide);
      end while (r > limit);
      return r;
    endfunction

    function void note_request(req_t req, logic wide, logic [63:0] bound);
      logic [63:0] limit;
      logic [63:0] v;
      limit = wide ? bound : {32'd0, bound[31:0]};
      case (req)
        REQ_UPTO:  v = draw_in_range(wide, limit);
        REQ_BELOW: v = (limit <= 64'd1) ? 64'd0 : draw_in_range(wide, limit - 64'd1);
        default:   v = next_draw(wide);   // raw and the spare code
      endcase
      draws_due.push_back(v);
    endfunction

    function void check_value(logic [63:0] actual);
      logic [63:0] want;
      if (draws_due.size() == 0) begin
        $error("out_value: word with nothing expected, actual %h", actual);
        failures++;
        return;
      end
      want = draws_due.pop_front();
      if (actual !== want) begin
        $error("out_value: expected %h, actual %h", want, actual);
        failures++;
      end
    endfunction

    function int unsigned pending();
      return draws_due.size();
    endfunction
  endclass

  // ---------------------------------------------------------------------------
  // DUT hookup; every input starts at a known value
  // ---------------------------------------------------------------------------
  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [ReqW-1:0]   in_req_type = REQ_RAW;
  logic              in_wide = 1'b0;
  logic [WordW-1:0]  in_bound = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [WordW-1:0]  out_value;
  logic              cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_index = CFG_SEED_LOW;
  logic [WordW-1:0]  cfg_data = '0;

  xorshift_bounded_random_top uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_req_type (in_req_type),
    .in_wide     (in_wide),
    .in_bound    (in_bound),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_value   (out_value),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  xbr_draw_scoreboard sb = new();

  always #2 clk = ~clk;

  // hard stop in case the block hangs
  int unsigned cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("xorshift_bounded_random_top test failed");
      $finish;
    end
  end

  // result side: check each accepted word
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_value(out_value);
  end

  // Receiver stall pattern. The mode follows the top bits of stall_tick: open,
  // random light, periodic, and nearly blocked, so stalls hit every sequencer state.
  logic [8:0] stall_tick = '0;
  always @(negedge clk) begin
    stall_tick <= stall_tick + 9'd1;
    case (stall_tick[8:7])
      2'd0: out_stall <= 1'b0;
      2'd1: out_stall <= ($urandom_range(0, 3) == 0);
      2'd2: out_stall <= (stall_tick[2:0] < 3'd3);
      default: out_stall <= ($urandom_range(0, 7) != 0);
    endcase
  end

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // present one request word and hold it until the block takes it
  task automatic send_request(req_t req, logic wide, logic [63:0] bound);
    @(negedge clk);
    in_valid = 1'b1;
    in_req_type = req;
    in_wide = wide;
    in_bound = bound;
    do @(posedge clk); while (in_stall);
    sb.note_request(req, wide, bound);
  endtask

  task automatic idle_sender(int unsigned n);
    @(negedge clk);
    in_valid = 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  // hold off until every expected word is back, then let the sequencer settle
  task automatic wait_drained(int unsigned settle);
    @(negedge clk);
    in_valid = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic write_seed(cfg_idx_t idx, logic [63:0] data);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    @(posedge clk);
    sb.load_seed(idx, data);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // bound mix: full range, tiny, random width, powers of two (and +1, the
  // worst case for rejection), extremes, and narrow words with junk on top
  function automatic logic [63:0] pick_bound();
    logic [63:0] b;
    int unsigned k;
    k = $urandom_range(0, 63);
    case ($urandom_range(0, 7))
      0, 7: b = {$urandom, $urandom};
      1: b = 64'($urandom_range(0, 20));
      2: b = {$urandom, $urandom} >> k;
      3: b = 64'd1 << k;
      4: b = (64'd1 << k) + 64'd1;
      5: begin
        case ($urandom_range(0, 4))
          0: b = 64'd0;
          1: b = 64'd1;
          2: b = 64'd2;
          3: b = {64{1'b1}};
          default: b = 64'h0000_0000_FFFF_FFFF;
        endcase
      end
      default: b = {$urandom, 32'($urandom_range(0, 40))};
    endcase
    return b;
  endfunction

  function automatic req_t pick_req();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 2) return REQ_RAW;
    if (r < 5) return REQ_UPTO;
    if (r < 9) return REQ_BELOW;
    return REQ_RSVD;
  endfunction

  // one phase of random traffic in bursts; no_gaps runs the sender flat out
  task automatic random_traffic(int unsigned count, bit no_gaps);
    int unsigned burst_left;
    burst_left = 0;
    for (int unsigned i = 0; i < count; i++) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 10);
        if (!no_gaps && $urandom_range(0, 3) != 0)
          idle_sender($urandom_range(1, 7));
      end
      // occasionally let the pipe run dry before going on
      if ($urandom_range(0, 99) == 0)
        wait_drained(0);
      send_request(pick_req(), 1'($urandom_range(0, 1)), pick_bound());
      burst_left--;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (2) @(negedge clk);
    rst_n = 1'b1;

    // directed: reset seed, both widths, every request code, the zero-result
    // cases, narrow mode ignoring the upper bound bits, and wide extremes
    send_request(REQ_RAW,   1'b0, 64'd0);
    send_request(REQ_RAW,   1'b1, 64'd0);
    send_request(REQ_UPTO,  1'b0, 64'd0);
    send_request(REQ_UPTO,  1'b1, 64'd0);
    send_request(REQ_BELOW, 1'b0, 64'd0);
    send_request(REQ_BELOW, 1'b1, 64'd1);
    send_request(REQ_BELOW, 1'b1, 64'd2);
    send_request(REQ_UPTO,  1'b0, 64'd1);
    send_request(REQ_UPTO,  1'b1, {64{1'b1}});
    send_request(REQ_UPTO,  1'b0, {64{1'b1}});
    send_request(REQ_UPTO,  1'b0, 64'hFFFF_FFFF_0000_0000);
    send_request(REQ_BELOW, 1'b0, 64'h0000_0001_0000_0001);
    send_request(REQ_BELOW, 1'b1, {64{1'b1}});
    send_request(REQ_RSVD,  1'b0, 64'd7);
    send_request(REQ_RSVD,  1'b1, 64'd7);
    send_request(REQ_UPTO,  1'b1, 64'h8000_0000_0000_0000);
    send_request(REQ_BELOW, 1'b1, 64'h8000_0000_0000_0000);
    send_request(REQ_UPTO,  1'b0, 64'h0000_0000_8000_0000);
    send_request(REQ_UPTO,  1'b1, 64'h0000_0001_0000_0000);
    send_request(REQ_BELOW, 1'b0, 64'd3);
    wait_drained(SettleCycles);

    // all-zero state: everything returns 0, bounded draws accept at once
    write_seed(CFG_SEED_LOW, 64'd0);
    write_seed(CFG_SEED_HIGH, 64'd0);
    send_request(REQ_RAW,   1'b0, 64'd0);
    send_request(REQ_RAW,   1'b1, 64'd0);
    send_request(REQ_UPTO,  1'b1, 64'd5);
    send_request(REQ_BELOW, 1'b0, {64{1'b1}});
    wait_drained(SettleCycles);

    // all-ones state, sender in bursts
    write_seed(CFG_SEED_LOW, {64{1'b1}});
    write_seed(CFG_SEED_HIGH, {64{1'b1}});
    random_traffic(RandPerPhase, 1'b0);
    wait_drained(SettleCycles);

    // random seed, sender with no idle gaps between bursts
    write_seed(CFG_SEED_HIGH, {$urandom, $urandom});
    write_seed(CFG_SEED_LOW, {$urandom, $urandom});
    random_traffic(RandPerPhase, 1'b1);
    wait_drained(SettleCycles);

    // only the high half rewritten; low half carries over from the run above
    write_seed(CFG_SEED_HIGH, 64'h0000_0000_0000_0001);
    random_traffic(RandPerPhase, 1'b0);
    wait_drained(SettleCycles);

    write_seed(CFG_SEED_LOW, {$urandom, $urandom});
    write_seed(CFG_SEED_HIGH, {$urandom, $urandom});
    random_traffic(RandPerPhase, 1'b0);
    wait_drained(SettleCycles);

    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("xorshift_bounded_random_top test passed");
    end else begin
      $display("xorshift_bounded_random_top test failed");
    end
    $finish;
  end

endmodule
